### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int OCC_W            = 5;

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_NOP  = 2'd3
    } spq_mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } spq_status_t;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } spq_entry_t;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

### rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of slots, head first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries mode, item_value and
//   item_priority. Output channel (out_valid / out_stall) returns one
//   transaction per input: out_value, status and occupancy.
//   Enqueue inserts behind all entries of equal or higher priority, so equal
//   priorities leave in arrival order. Dequeue pops the head, peek reads it.
//   Empty dequeue/peek gives status empty and value -1; enqueue on a full
//   queue is dropped with status full.
//   Latency: the result is registered at the accepting edge and is valid in
//   the following cycle.
//   Throughput: one operation per cycle; every slot compares its priority
//   against the incoming one in parallel and the chain shifts in one step.
//   Stall: while a result waits with out_stall high, in_stall is raised and
//   no new operation is taken; nothing is lost.
//   Reset: rst_n clears the entry count and the output valid flag; slot
//   contents are not cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          mode,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_priority,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]   out_value,
    output logic [1:0]                          status,
    output logic [spq_pkg::OCC_W-1:0]           occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;
    spq_status_t        status_reg;
    spq_status_t        status_next;
    logic [OCC_W-1:0]   occupancy_reg;

    logic               accept;
    logic               full;
    logic               empty;
    spq_mode_t          op;
    spq_ctrl_t          ctrl;
    spq_entry_t         new_entry;
    spq_entry_t         cell_entry [CAPACITY];
    logic               cell_stay  [CAPACITY];

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign op        = spq_mode_t'(mode);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign new_entry = '{value: item_value, prio: item_priority};

    assign ctrl.enq = accept && (op == MODE_ENQ) && !full;
    assign ctrl.deq = accept && (op == MODE_DEQ) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CNT_W'(gi)),
                .prev_stay  ((gi == 0) ? 1'b1 : cell_stay[(gi == 0) ? 0 : gi - 1]),
                .new_entry  (new_entry),
                .prev_entry ((gi == 0) ? new_entry : cell_entry[(gi == 0) ? 0 : gi - 1]),
                .next_entry ((gi == CAPACITY - 1) ? new_entry
                                : cell_entry[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .entry      (cell_entry[gi]),
                .stay       (cell_stay[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = STAT_OK;
        case (op)
            MODE_ENQ:
            begin
                if (full)
                    status_next = STAT_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            MODE_DEQ, MODE_PEEK:
            begin
                if (empty)
                begin
                    out_value_next = EMPTY_VALUE;
                    status_next    = STAT_EMPTY;
                end
                else
                begin
                    out_value_next = cell_entry[0].value;
                    if (op == MODE_DEQ)
                        count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not decrement count");

    a_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == MODE_ENQ) && full
            |=> status_reg == STAT_FULL && count_reg == $past(count_reg))
        else $error("full enqueue not dropped");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == STAT_EMPTY) |-> out_value_reg == EMPTY_VALUE)
        else $error("empty result without -1 value");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> !(cell_entry[0].prio < cell_entry[1].prio))
        else $error("head slots out of order");

endmodule

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts toward the tail on
// insert, toward the head on removal.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                clk,
    input  spq_pkg::spq_ctrl_t  ctrl,
    input  logic                occupied,
    input  logic                prev_stay,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t prev_entry,
    input  spq_pkg::spq_entry_t next_entry,
    output spq_pkg::spq_entry_t entry,
    output logic                stay
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Entry keeps its slot when it ranks at or above the incoming one
    assign stay = occupied && !(entry_reg.prio < new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && !stay)
        begin
            // first slot that gives way takes the new entry
            entry_next = prev_stay ? new_entry : prev_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### test/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A directed table covers
// empty/full corners, extreme fields and priority ties. Random bursts that
// lean toward filling, draining or an even mix follow. Results are compared
// with a behavioral queue copy in the bench or a pinned row's typed result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int DEPTH       = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BURST_LEN   = 40;
    localparam int NUM_BURSTS  = 30;
    localparam int TABLE_LEN   = 26;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        spq_status_t              stat;
        logic [OCC_W-1:0]         occ;
    } queue_result_t;

    typedef struct packed {
        spq_mode_t                op;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
        logic                     pinned;
        queue_result_t            want;
    } op_row_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode          = MODE_NOP;
    logic signed [DATA_W-1:0] item_value    = '0;
    logic signed [DATA_W-1:0] item_priority = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    // typed-in expectation travels with the offered transaction
    logic                     pin_valid     = 1'b0;
    queue_result_t            pin_result    = '0;

    logic                     send_idle_on  = 1'b1;
    logic                     recv_idle_on  = 1'b1;
    int                       hold_left     = 0;
    int                       fail_count    = 0;
    int                       cycle_count   = 0;

    // bench copy of the queue, slot 0 is the head
    logic signed [DATA_W-1:0] model_val [DEPTH];
    logic signed [DATA_W-1:0] model_pri [DEPTH];
    int                       model_count;

    queue_result_t            pending_results [$];
    op_row_t                  op_table [TABLE_LEN];

    sorted_priority_queue #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .status        (status),
        .occupancy     (occupancy)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic apply_op(input spq_mode_t op, input logic signed [DATA_W-1:0] v,
                            input logic signed [DATA_W-1:0] p, output queue_result_t r);
        int pos;
        r = '{value: '0, stat: STAT_OK, occ: '0};
        case (op)
            MODE_ENQ:
            begin
                if (model_count >= DEPTH)
                begin
                    r.stat = STAT_FULL;
                end
                else
                begin
                    // goes behind every entry of equal or higher priority
                    pos = model_count;
                    for (int i = 0; i < model_count; i++)
                    begin
                        if (model_pri[i] < p)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_val[i] = model_val[i-1];
                        model_pri[i] = model_pri[i-1];
                    end
                    model_val[pos] = v;
                    model_pri[pos] = p;
                    model_count++;
                end
            end
            MODE_DEQ, MODE_PEEK:
            begin
                if (model_count == 0)
                begin
                    r.value = EMPTY_VALUE;
                    r.stat  = STAT_EMPTY;
                end
                else
                begin
                    r.value = model_val[0];
                    if (op == MODE_DEQ)
                    begin
                        for (int i = 1; i < model_count; i++)
                        begin
                            model_val[i-1] = model_val[i];
                            model_pri[i-1] = model_pri[i];
                        end
                        model_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occ = model_count[OCC_W-1:0];
    endtask

    // predict on input transactions and check output transactions in one place,
    // so the order of the two within an edge never matters
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
            begin
                apply_op(spq_mode_t'(mode), item_value, item_priority, want);
                if (pin_valid)
                begin
                    want = pin_result;
                end
                pending_results.push_back(want);
            end
            if (out_valid === 1'b1 && !out_stall)
            begin
                got = '{value: out_value, stat: spq_status_t'(status), occ: occupancy};
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result: value %0d status %0d occupancy %0d",
                                 got.value, got.stat, got.occ);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.value !== want.value || got.stat !== want.stat ||
                        got.occ !== want.occ)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            // value/status/occupancy
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.value, want.stat, want.occ,
                                     got.value, got.stat, got.occ);
                        end
                    end
                end
            end
        end
    end

    // receiver: random stall, a long hold-off when requested, or no stall when idling is off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (recv_idle_on)
            begin
                out_stall <= ($urandom_range(99) < 25);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_op(input spq_mode_t op, input logic signed [DATA_W-1:0] v,
                           input logic signed [DATA_W-1:0] p, input logic pinned,
                           input queue_result_t want);
        @(negedge clk);
        while (send_idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= op;
        item_value    <= v;
        item_priority <= p;
        pin_valid     <= pinned;
        pin_result    <= want;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        spq_mode_t                op;
        logic signed [DATA_W-1:0] pri;
        int                       bias;
        int                       roll;

        model_count = 0;
        op_table = '{
            '{MODE_PEEK, 32'h1234_5678, 32'h0, 1'b1, '{EMPTY_VALUE, STAT_EMPTY, 5'd0}},
            '{MODE_DEQ,  32'hdead_beef, 32'h7fff_ffff, 1'b1, '{EMPTY_VALUE, STAT_EMPTY, 5'd0}},
            '{MODE_NOP,  32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'sd0, STAT_OK, 5'd0}},
            '{MODE_ENQ,  32'h7fff_ffff, 32'h8000_0000, 1'b1, '{32'sd0, STAT_OK, 5'd1}},
            '{MODE_ENQ,  32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'sd0, STAT_OK, 5'd2}},
            '{MODE_PEEK, 32'h0, 32'h0, 1'b1, '{32'sh8000_0000, STAT_OK, 5'd2}},
            // ties at both ends of the priority range
            '{MODE_ENQ,  32'd11, 32'h7fff_ffff, 1'b0, '0},
            '{MODE_ENQ,  32'd12, 32'h8000_0000, 1'b0, '0},
            '{MODE_DEQ,  32'hffff_ffff, 32'h0, 1'b0, '0},
            '{MODE_DEQ,  32'h0, 32'hffff_ffff, 1'b0, '0},
            '{MODE_ENQ,  32'd21, 32'h0, 1'b0, '0},
            '{MODE_ENQ,  32'd22, 32'hffff_ffff, 1'b0, '0},
            '{MODE_ENQ,  32'd23, 32'h0000_0001, 1'b0, '0},
            '{MODE_ENQ,  32'd24, 32'h0, 1'b0, '0},
            '{MODE_ENQ,  32'hffff_ffff, 32'h5555_5555, 1'b0, '0},
            '{MODE_ENQ,  32'haaaa_aaaa, 32'haaaa_aaaa, 1'b0, '0},
            '{MODE_ENQ,  32'h0, 32'h7fff_fffe, 1'b0, '0},
            '{MODE_ENQ,  32'd28, 32'h8000_0001, 1'b0, '0},
            '{MODE_ENQ,  32'd29, 32'h0, 1'b0, '0},
            '{MODE_ENQ,  32'd30, 32'hffff_fffe, 1'b0, '0},
            '{MODE_ENQ,  32'd31, 32'h7fff_ffff, 1'b0, '0},
            '{MODE_ENQ,  32'd32, 32'h8000_0000, 1'b0, '0},
            '{MODE_ENQ,  32'd33, 32'h0000_0100, 1'b0, '0},
            '{MODE_ENQ,  32'd34, 32'h0, 1'b0, '0},
            '{MODE_ENQ,  32'd35, 32'h7fff_ffff, 1'b1, '{32'sd0, STAT_FULL, 5'd16}},
            '{MODE_NOP,  32'h0, 32'h0, 1'b1, '{32'sd0, STAT_OK, 5'd16}}
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (op_table[i])
        begin
            push_op(op_table[i].op, op_table[i].val, op_table[i].pri,
                    op_table[i].pinned, op_table[i].want);
        end

        // bursts lean toward fill (0), drain (1) or an even mix (2)
        for (int b = 0; b < NUM_BURSTS; b++)
        begin
            bias = b % 3;
            send_idle_on = !(b >= 10 && b < 15);
            recv_idle_on = !(b >= 10 && b < 15);
            if (b == 4 || b == 20)
            begin
                bias      = 0;
                hold_left = HOLD_CYCLES;
            end
            for (int k = 0; k < BURST_LEN; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                begin
                    op = MODE_NOP;
                end
                else if (roll < (bias == 0 ? 78 : (bias == 1 ? 28 : 50)))
                begin
                    op = MODE_ENQ;
                end
                else if (roll < (bias == 1 ? 85 : 88))
                begin
                    op = MODE_DEQ;
                end
                else
                begin
                    op = MODE_PEEK;
                end
                case ($urandom_range(3))
                    0: pri = $urandom;
                    1: pri = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                    default: pri = $signed($urandom_range(4)) - 2;
                endcase
                push_op(op, $urandom, pri, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid  <= 1'b0;
        pin_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
